// File: src/dps_pkg.sv
// ----------------------------------------------------------------------------
// dps_pkg
// shared constants and types of the dependency priority scheduler
// ----------------------------------------------------------------------------
package dps_pkg;

    localparam int TableSlotsDef = 16;
    localparam int BatchLimitDef = 16;
    localparam int MaxResults    = 16;
    localparam int QueueDepth    = 2;

    localparam logic [2:0] K_ADD      = 3'd0;
    localparam logic [2:0] K_COMPLETE = 3'd1;
    localparam logic [2:0] K_CANCEL   = 3'd2;
    localparam logic [2:0] K_DISPATCH = 3'd3;
    localparam logic [2:0] K_QUERY    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam logic [1:0] PH_PENDING = 2'd0;
    localparam logic [1:0] PH_READY   = 2'd1;
    localparam logic [1:0] PH_RUNNING = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    // one classified operation as it waits in the queue
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] req_id;
        logic [63:0] pred_id;
        logic [7:0]  prio;
        logic [4:0]  cap;
    } t_op;

    // one result item
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] out_id;
        logic [7:0]  out_prio;
        logic        can_run;
        logic [7:0]  qry_prio;
        logic [4:0]  ready_count;
        logic [4:0]  pending_count;
        logic        last;
    } t_res;

endpackage

// File: src/dps_front.sv
// ----------------------------------------------------------------------------
// dps_front
// accepts operations, clamps the batch size and queues them for the engine
// ----------------------------------------------------------------------------
module dps_front
    import dps_pkg::*;
#(
    parameter int BATCH_LIMIT = BatchLimitDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [63:0] i_req_id,
    input  logic [63:0] i_pred_id,
    input  logic [7:0]  i_priority_req,
    input  logic [4:0]  i_batch_max,
    output logic        o_op_valid,
    input  logic        i_op_take,
    output t_op         o_op
);
    localparam int CapMax = (BATCH_LIMIT < MaxResults) ? BATCH_LIMIT : MaxResults;

    t_op  r_q [QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_op  w_op;
    logic w_push, w_pop;

    // batch size clamp
    always_comb begin
        w_op         = '0;
        w_op.kind    = i_kind;
        w_op.req_id  = i_req_id;
        w_op.pred_id = i_pred_id;
        w_op.prio    = i_priority_req;
        if (i_batch_max == 5'd0)
            w_op.cap = 5'd1;
        else if (int'(i_batch_max) > CapMax)
            w_op.cap = 5'(CapMax);
        else
            w_op.cap = i_batch_max;
    end

    assign o_stall    = (r_cnt == 2'(QueueDepth));
    assign w_push     = i_valid && !o_stall;
    assign o_op_valid = (r_cnt != 2'd0);
    assign w_pop      = o_op_valid && i_op_take;
    assign o_op       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_op;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QueueDepth)) else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QueueDepth)) |-> o_stall) else $error("full without stall");
endmodule

// File: src/dps_engine.sv
// ----------------------------------------------------------------------------
// dps_engine
// slot table and sequencer that carries out one operation at a time
// ----------------------------------------------------------------------------
module dps_engine
    import dps_pkg::*;
#(
    parameter int TABLE_SLOTS = TableSlotsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_absent,
    input  logic        i_op_valid,
    output logic        o_op_take,
    input  t_op         i_op,
    output logic        o_valid,
    input  logic        i_stall,
    output t_res        o_res
);
    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int PW = CW + 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_FIND   = 10'b0000000010,
        S_EXEC   = 10'b0000000100,
        S_BOOST  = 10'b0000001000,
        S_REL    = 10'b0000010000,
        S_CANC   = 10'b0000100000,
        S_DSCAN  = 10'b0001000000,
        S_DPICK  = 10'b0010000000,
        S_COUNT  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state r_state;
    t_op    r_op;

    // slot table
    logic              r_used   [TABLE_SLOTS];
    logic [63:0]       r_id     [TABLE_SLOTS];
    logic [63:0]       r_pid    [TABLE_SLOTS];
    logic              r_linked [TABLE_SLOTS];
    logic [IW-1:0]     r_link   [TABLE_SLOTS];
    logic [7:0]        r_base   [TABLE_SLOTS];
    logic [7:0]        r_eff    [TABLE_SLOTS];
    logic              r_boost  [TABLE_SLOTS];
    logic [1:0]        r_phase  [TABLE_SLOTS];
    logic [31:0]       r_rstamp [TABLE_SLOTS];
    logic [31:0]       r_astamp [TABLE_SLOTS];
    logic              r_mark   [TABLE_SLOTS];
    logic [31:0]       r_stamp;

    // scan control
    logic [CW-1:0] r_idx;
    logic          r_found;
    logic [IW-1:0] r_best;
    logic [31:0]   r_bage;
    logic [IW-1:0] r_tgt;      // slot the operation names
    logic [IW-1:0] r_child, r_par;
    logic [PW-1:0] r_pass;
    logic          r_chg;
    logic [4:0]    r_k;
    logic [CW-1:0] r_rc, r_pc;
    logic [CW-1:0] r_dn;       // results this dispatch hands out
    logic [1:0]    r_status;
    logic [63:0]   r_oid;
    logic [7:0]    r_oprio;
    logic          r_cr;
    logic [7:0]    r_ep;
    logic          r_more;     // dispatch has more to hand out after this result
    logic          r_oval;
    t_res          r_res;

    logic [IW-1:0] w_i;
    logic [31:0]   w_age, w_rage;
    logic          w_idx_end;
    logic [CW-1:0] w_dn;

    // counts saturate at the width of the result fields
    function automatic logic [4:0] sat_count(logic [CW-1:0] v);
        return (int'(v) > 31) ? 5'd31 : 5'(v);
    endfunction

    assign w_i       = r_idx[IW-1:0];
    assign w_age     = r_stamp - r_astamp[w_i];
    assign w_rage    = r_stamp - r_rstamp[w_i];
    assign w_idx_end = (r_idx == CW'(TABLE_SLOTS - 1));
    assign w_dn      = (int'(r_rc) < int'(r_op.cap)) ? r_rc : CW'(r_op.cap);
    assign o_op_take = (r_state == S_IDLE) && i_op_valid;
    assign o_valid   = r_oval;
    assign o_res     = r_res;

    // sequencer, one slot looked at per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_stamp <= 32'd0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_used[i] <= 1'b0; r_linked[i] <= 1'b0; r_boost[i] <= 1'b0;
            end
        end else begin
            if (r_oval && !i_stall) r_oval <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_op_valid) begin
                        r_op <= i_op; r_idx <= '0; r_found <= 1'b0; r_k <= 5'd0;
                        r_status <= ST_OK; r_oid <= '0; r_oprio <= '0;
                        r_cr <= 1'b0; r_ep <= '0;
                        if (i_op.kind == K_ADD) r_state <= S_FIND;
                        else if (i_op.kind == K_COMPLETE || i_op.kind == K_CANCEL ||
                                 i_op.kind == K_QUERY) r_state <= S_FIND;
                        else begin
                            r_rc <= '0; r_pc <= '0; r_state <= S_COUNT;
                        end
                    end
                end
                // add: lowest free slot; others: newest slot holding the id
                S_FIND: begin
                    if (r_op.kind == K_ADD) begin
                        if (!r_found && !r_used[w_i]) begin
                            r_found <= 1'b1; r_tgt <= w_i;
                        end
                    end else if (r_used[w_i] && r_id[w_i] == r_op.req_id &&
                                 (!r_found || w_age < r_bage)) begin
                        r_found <= 1'b1; r_tgt <= w_i; r_bage <= w_age;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (w_idx_end) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_idx <= '0; r_rc <= '0; r_pc <= '0;
                    if (r_op.kind == K_ADD) begin
                        if (!r_found) begin
                            r_status <= ST_FULL; r_state <= S_COUNT;
                        end else begin
                            r_used[r_tgt] <= 1'b1; r_id[r_tgt] <= r_op.req_id;
                            r_pid[r_tgt] <= r_op.pred_id; r_base[r_tgt] <= r_op.prio;
                            r_eff[r_tgt] <= r_op.prio; r_boost[r_tgt] <= 1'b0;
                            r_linked[r_tgt] <= 1'b0; r_link[r_tgt] <= '0;
                            r_rstamp[r_tgt] <= 32'd0; r_astamp[r_tgt] <= r_stamp;
                            r_stamp <= r_stamp + 32'd1;
                            r_found <= 1'b0; r_child <= r_tgt;
                            // reuse find loop for predecessor via boost state
                            r_state <= S_BOOST; r_pass <= '0; r_chg <= 1'b0;
                        end
                    end else if (!r_found) begin
                        r_status <= ST_NOTFOUND;
                        if (r_op.kind == K_QUERY) r_ep <= i_absent;
                        r_state <= S_COUNT;
                    end else if (r_op.kind == K_QUERY) begin
                        r_cr <= (r_phase[r_tgt] == PH_READY) ||
                                (r_phase[r_tgt] == PH_RUNNING);
                        r_ep <= r_eff[r_tgt];
                        r_state <= S_COUNT;
                    end else if (r_op.kind == K_COMPLETE) begin
                        r_phase[r_tgt] <= PH_DONE;
                        if (r_boost[r_tgt]) begin
                            r_eff[r_tgt] <= r_base[r_tgt]; r_boost[r_tgt] <= 1'b0;
                        end
                        r_found <= 1'b0; r_state <= S_REL;
                    end else begin
                        for (int i = 0; i < TABLE_SLOTS; i++)
                            r_mark[i] <= (IW'(i) == r_tgt);
                        r_chg <= 1'b0; r_state <= S_CANC;
                    end
                end
                // add: predecessor search (r_pass 0), then one chain link per cycle
                S_BOOST: begin
                    if (r_pass == '0) begin
                        if (r_op.pred_id != 64'd0 && r_used[w_i] && w_i != r_child &&
                            r_id[w_i] == r_op.pred_id &&
                            (!r_found || w_age < r_bage)) begin
                            r_found <= 1'b1; r_par <= w_i; r_bage <= w_age;
                        end
                        r_idx <= r_idx + 1'b1;
                        if (w_idx_end) begin
                            r_pass <= PW'(1);
                            r_idx <= '0;
                        end
                    end else if (r_pass == PW'(1)) begin
                        if (r_found && r_phase[r_par] != PH_DONE) begin
                            r_linked[r_child] <= 1'b1; r_link[r_child] <= r_par;
                            r_phase[r_child] <= PH_PENDING;
                            r_pass <= PW'(2);
                        end else begin
                            r_phase[r_child] <= PH_READY;
                            r_rstamp[r_child] <= r_stamp;
                            r_stamp <= r_stamp + 32'd1;
                            r_state <= S_COUNT;
                        end
                    end else begin
                        if (r_eff[r_child] <= r_eff[r_par] ||
                            r_pass == PW'(TABLE_SLOTS + 1)) begin
                            r_state <= S_COUNT;
                        end else begin
                            r_eff[r_par] <= r_eff[r_child]; r_boost[r_par] <= 1'b1;
                            if (r_phase[r_par] == PH_READY) begin
                                r_rstamp[r_par] <= r_stamp;
                                r_stamp <= r_stamp + 32'd1;
                            end
                            if (r_pid[r_par] != 64'd0 && r_phase[r_par] == PH_PENDING &&
                                r_linked[r_par]) begin
                                r_child <= r_par; r_par <= r_link[r_par];
                                r_pass <= r_pass + 1'b1;
                            end else r_state <= S_COUNT;
                        end
                    end
                end
                // complete: release oldest linked successor per sweep
                S_REL: begin
                    if (r_used[w_i] && r_linked[w_i] && r_link[w_i] == r_tgt &&
                        (!r_found || w_age > r_bage)) begin
                        r_found <= 1'b1; r_best <= w_i; r_bage <= w_age;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (w_idx_end) begin
                        r_idx <= '0;
                        if (!r_found && !(r_used[w_i] && r_linked[w_i] &&
                                          r_link[w_i] == r_tgt)) begin
                            r_state <= S_COUNT;
                        end
                    end
                    if (r_idx == '0 && r_found) begin
                        // apply last sweep's pick before scanning again
                        r_found <= 1'b0;
                        r_linked[r_best] <= 1'b0;
                        if (r_phase[r_best] == PH_PENDING) begin
                            r_phase[r_best] <= PH_READY;
                            if (r_boost[r_best]) begin
                                r_eff[r_best] <= r_base[r_best];
                                r_boost[r_best] <= 1'b0;
                            end
                            r_rstamp[r_best] <= r_stamp;
                            r_stamp <= r_stamp + 32'd1;
                        end
                        r_idx <= '0;
                    end
                end
                // cancel: propagate marks a slot at a time until stable
                S_CANC: begin
                    if (r_used[w_i] && r_linked[w_i] && r_mark[r_link[w_i]] &&
                        !r_mark[w_i]) begin
                        r_mark[w_i] <= 1'b1; r_chg <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (w_idx_end) begin
                        r_idx <= '0; r_chg <= 1'b0;
                        if (!r_chg && !(r_used[w_i] && r_linked[w_i] &&
                                        r_mark[r_link[w_i]] && !r_mark[w_i])) begin
                            for (int i = 0; i < TABLE_SLOTS; i++)
                                if (r_mark[i]) begin
                                    r_used[i] <= 1'b0; r_linked[i] <= 1'b0;
                                    r_boost[i] <= 1'b0;
                                end
                            r_state <= S_COUNT;
                        end
                    end
                end
                // dispatch: best ready slot; the first scan also fixes the batch size
                S_DSCAN: begin
                    if (r_idx == '0) r_found <= 1'b0;
                    if (r_idx == '0 && r_k == 5'd0) begin
                        r_dn <= w_dn; r_rc <= r_rc - w_dn;
                    end
                    if (r_used[w_i] && r_phase[w_i] == PH_READY &&
                        (!(r_found && r_idx != '0) || r_eff[w_i] > r_eff[r_best] ||
                         (r_eff[w_i] == r_eff[r_best] && w_rage > r_bage))) begin
                        r_found <= 1'b1; r_best <= w_i; r_bage <= w_rage;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (w_idx_end) r_state <= S_DPICK;
                end
                S_DPICK: begin
                    if (!r_found) begin
                        r_status <= ST_NONE; r_more <= 1'b0;
                    end else begin
                        r_phase[r_best] <= PH_RUNNING;
                        r_oid <= r_id[r_best]; r_oprio <= r_eff[r_best];
                        r_k <= r_k + 5'd1;
                        r_more <= (int'(r_k) + 1 < int'(r_dn));
                    end
                    r_state <= S_OUT;
                end
                // counts after the step; dispatch counts first and takes off its batch
                S_COUNT: begin
                    if (r_used[w_i] && r_phase[w_i] == PH_READY)   r_rc <= r_rc + 1'b1;
                    if (r_used[w_i] && r_phase[w_i] == PH_PENDING) r_pc <= r_pc + 1'b1;
                    r_idx <= r_idx + 1'b1;
                    if (w_idx_end) begin
                        r_idx <= '0;
                        if (r_op.kind == K_DISPATCH) r_state <= S_DSCAN;
                        else r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_oval || !i_stall) begin
                        r_oval <= 1'b1;
                        r_res  <= '{status: r_status, out_id: r_oid, out_prio: r_oprio,
                                    can_run: r_cr, qry_prio: r_ep,
                                    ready_count: sat_count(r_rc),
                                    pending_count: sat_count(r_pc),
                                    last: (r_op.kind != K_DISPATCH) || !r_more};
                        r_idx <= '0;
                        if (r_op.kind == K_DISPATCH && r_more) r_state <= S_DSCAN;
                        else r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op_take |-> (r_state == S_IDLE)) else $error("take while busy");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && i_stall) |=> (r_oval && $stable(r_res))) else $error("result lost");
    a_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= 5'(MaxResults)) else $error("batch over limit");
endmodule

// File: src/dependency_priority_scheduler.sv
// ----------------------------------------------------------------------------
// dependency_priority_scheduler
// request table scheduler with dependency chains and priority inheritance
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// input    in         i_valid / o_stall     i_kind i_req_id i_pred_id i_priority_req i_batch_max
// output   out        o_valid / i_stall     o_status o_out_id o_out_prio o_can_run ...
// config   in         i_cfg_we              i_cfg_data (absent_priority)
//
// one operation at a time; each pass walks over every slot of the table.
// add: a free-slot pass, a predecessor pass, one step per boosted link and a
// counting pass; complete: one pass per released successor; cancel: one pass
// per subtree level; dispatch: a counting pass, then one pass per result.
// reset is synchronous; the table needs no clearing pass. a two-entry queue
// lets operations be taken while the engine is busy.
// ----------------------------------------------------------------------------
module dependency_priority_scheduler
    import dps_pkg::*;
#(
    parameter int TABLE_SLOTS = TableSlotsDef,
    parameter int BATCH_LIMIT = BatchLimitDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [63:0] i_req_id,
    input  logic [63:0] i_pred_id,
    input  logic [7:0]  i_priority_req,
    input  logic [4:0]  i_batch_max,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_out_id,
    output logic [7:0]  o_out_prio,
    output logic        o_can_run,
    output logic [7:0]  o_qry_prio,
    output logic [4:0]  o_ready_count,
    output logic [4:0]  o_pending_count,
    output logic        o_last
);
    logic [7:0] r_absent;
    logic       w_op_valid, w_op_take;
    t_op        w_op;
    t_res       w_res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_absent <= 8'd4;
        else if (i_cfg_we) r_absent <= i_cfg_data;
    end

    dps_front #(.BATCH_LIMIT(BATCH_LIMIT)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .i_req_id, .i_pred_id,
        .i_priority_req, .i_batch_max,
        .o_op_valid(w_op_valid), .i_op_take(w_op_take), .o_op(w_op)
    );

    dps_engine #(.TABLE_SLOTS(TABLE_SLOTS)) u_engine (
        .i_clk, .i_rst_n, .i_absent(r_absent),
        .i_op_valid(w_op_valid), .o_op_take(w_op_take), .i_op(w_op),
        .o_valid, .i_stall, .o_res(w_res)
    );

    assign o_status        = w_res.status;
    assign o_out_id        = w_res.out_id;
    assign o_out_prio      = w_res.out_prio;
    assign o_can_run       = w_res.can_run;
    assign o_qry_prio      = w_res.qry_prio;
    assign o_ready_count   = w_res.ready_count;
    assign o_pending_count = w_res.pending_count;
    assign o_last          = w_res.last;
endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dependency priority scheduler: a scoreboard
// models the request table, predicts every result and checks the results in
// order while random bursts, stalls and register updates exercise the block
// ----------------------------------------------------------------------------
module tb;
    import dps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;

    // table model and expected result store
    class sched_scoreboard;
        bit          used     [SLOTS];
        bit [63:0]   rid      [SLOTS];
        bit [63:0]   pid      [SLOTS];
        bit          linked   [SLOTS];
        bit [3:0]    link_idx [SLOTS];
        bit [7:0]    base     [SLOTS];
        bit [7:0]    eff      [SLOTS];
        bit          boosted  [SLOTS];
        bit [1:0]    phase    [SLOTS];
        bit [31:0]   rstamp   [SLOTS];
        bit [31:0]   astamp   [SLOTS];
        bit [31:0]   stamp;
        bit [7:0]    absent_prio;
        t_res        expected_results[$];
        int          n_fail;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                used[i] = 0;
                linked[i] = 0;
                boosted[i] = 0;
            end
            stamp = 0;
            absent_prio = 8'd4;
            n_fail = 0;
        endfunction

        function bit [31:0] next_stamp();
            next_stamp = stamp;
            stamp = stamp + 1;
        endfunction

        // most recently added live slot holding the id
        function int lookup(bit [63:0] id, int skip);
            int best;
            bit [31:0] best_age;
            bit [31:0] age;
            best = -1;
            best_age = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (!used[i] || i == skip || rid[i] != id) continue;
                age = stamp - astamp[i];
                if (best < 0 || age < best_age) begin
                    best = i;
                    best_age = age;
                end
            end
            return best;
        endfunction

        // priority inheritance up the pending chain
        function void raise_chain(int child, int par);
            for (int n = 0; n < SLOTS; n++) begin
                if (eff[child] <= eff[par]) return;
                eff[par] = eff[child];
                boosted[par] = 1;
                if (phase[par] == PH_READY) rstamp[par] = next_stamp();
                if (pid[par] != 0 && phase[par] == PH_PENDING && linked[par]) begin
                    child = par;
                    par = link_idx[par];
                end else begin
                    return;
                end
            end
        endfunction

        function void restore(int s);
            if (boosted[s]) begin
                eff[s] = base[s];
                boosted[s] = 0;
            end
        endfunction

        function t_res blank(bit [1:0] st);
            t_res r;
            r = '0;
            r.status = st;
            return r;
        endfunction

        function void note_input(bit [2:0] kind, bit [63:0] id, bit [63:0] pred,
                                 bit [7:0] prio, bit [4:0] bmax);
            t_res res[$];
            t_res r;
            int s;
            int p;
            int best;
            int cap;
            int nr;
            int np;
            bit [31:0] best_age;
            bit [31:0] age;
            bit mark[SLOTS];
            case (kind)
                K_ADD: begin
                    s = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (!used[i] && s < 0) s = i;
                    if (s < 0) begin
                        res.push_back(blank(ST_FULL));
                    end else begin
                        used[s] = 1;
                        rid[s] = id;
                        pid[s] = pred;
                        base[s] = prio;
                        eff[s] = prio;
                        boosted[s] = 0;
                        linked[s] = 0;
                        link_idx[s] = 0;
                        rstamp[s] = 0;
                        astamp[s] = next_stamp();
                        p = (pred != 0) ? lookup(pred, s) : -1;
                        if (p >= 0 && phase[p] != PH_DONE) begin
                            linked[s] = 1;
                            link_idx[s] = p[3:0];
                            phase[s] = PH_PENDING;
                            raise_chain(s, p);
                        end else begin
                            phase[s] = PH_READY;
                            rstamp[s] = next_stamp();
                        end
                        res.push_back(blank(ST_OK));
                    end
                end
                K_COMPLETE: begin
                    s = lookup(id, -1);
                    if (s < 0) begin
                        res.push_back(blank(ST_NOTFOUND));
                    end else begin
                        phase[s] = PH_DONE;
                        restore(s);
                        // release successors oldest first
                        for (int n = 0; n < SLOTS; n++) begin
                            best = -1;
                            best_age = 0;
                            for (int i = 0; i < SLOTS; i++) begin
                                if (!used[i] || !linked[i] || link_idx[i] != s[3:0]) continue;
                                age = stamp - astamp[i];
                                if (best < 0 || age > best_age) begin
                                    best = i;
                                    best_age = age;
                                end
                            end
                            if (best < 0) break;
                            linked[best] = 0;
                            if (phase[best] == PH_PENDING) begin
                                phase[best] = PH_READY;
                                restore(best);
                                rstamp[best] = next_stamp();
                            end
                        end
                        res.push_back(blank(ST_OK));
                    end
                end
                K_CANCEL: begin
                    s = lookup(id, -1);
                    if (s < 0) begin
                        res.push_back(blank(ST_NOTFOUND));
                    end else begin
                        for (int i = 0; i < SLOTS; i++) mark[i] = 0;
                        mark[s] = 1;
                        for (int n = 0; n < SLOTS; n++)
                            for (int i = 0; i < SLOTS; i++)
                                if (used[i] && linked[i] && mark[link_idx[i]]) mark[i] = 1;
                        for (int i = 0; i < SLOTS; i++)
                            if (mark[i]) begin
                                used[i] = 0;
                                linked[i] = 0;
                                boosted[i] = 0;
                            end
                        res.push_back(blank(ST_OK));
                    end
                end
                K_DISPATCH: begin
                    cap = (bmax == 0) ? 1 : int'(bmax);
                    if (cap > 16) cap = 16;
                    while (res.size() < cap) begin
                        best = -1;
                        best_age = 0;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!used[i] || phase[i] != PH_READY) continue;
                            age = stamp - rstamp[i];
                            if (best < 0 || eff[i] > eff[best] ||
                                (eff[i] == eff[best] && age > best_age)) begin
                                best = i;
                                best_age = age;
                            end
                        end
                        if (best < 0) break;
                        phase[best] = PH_RUNNING;
                        r = blank(ST_OK);
                        r.out_id = rid[best];
                        r.out_prio = eff[best];
                        res.push_back(r);
                    end
                    if (res.size() == 0) res.push_back(blank(ST_NONE));
                end
                K_QUERY: begin
                    s = lookup(id, -1);
                    if (s < 0) begin
                        r = blank(ST_NOTFOUND);
                        r.qry_prio = absent_prio;
                    end else begin
                        r = blank(ST_OK);
                        r.can_run = (phase[s] == PH_READY || phase[s] == PH_RUNNING);
                        r.qry_prio = eff[s];
                    end
                    res.push_back(r);
                end
                default: res.push_back(blank(ST_OK));
            endcase
            nr = 0;
            np = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (used[i] && phase[i] == PH_READY) nr++;
                if (used[i] && phase[i] == PH_PENDING) np++;
            end
            foreach (res[k]) begin
                r = res[k];
                r.ready_count = nr[4:0];
                r.pending_count = np[4:0];
                r.last = (k == res.size() - 1);
                expected_results.push_back(r);
            end
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
            n_fail++;
        endtask

        task check_field(string what, logic [63:0] got, logic [63:0] want);
            if (got !== want) report_mismatch(what, got, want);
        endtask

        task check_result(t_res got);
            t_res want;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, status", 64'(got.status), 64'hx);
            end else begin
                want = expected_results.pop_front();
                check_field("status", 64'(got.status), 64'(want.status));
                check_field("out_id", got.out_id, want.out_id);
                check_field("out_prio", 64'(got.out_prio), 64'(want.out_prio));
                check_field("can_run", 64'(got.can_run), 64'(want.can_run));
                check_field("qry_prio", 64'(got.qry_prio), 64'(want.qry_prio));
                check_field("ready_count", 64'(got.ready_count), 64'(want.ready_count));
                check_field("pending_count", 64'(got.pending_count),
                            64'(want.pending_count));
                check_field("last", 64'(got.last), 64'(want.last));
            end
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [2:0]  i_kind = '0;
    logic [63:0] i_req_id = '0;
    logic [63:0] i_pred_id = '0;
    logic [7:0]  i_priority_req = '0;
    logic [4:0]  i_batch_max = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_status;
    logic [63:0] o_out_id;
    logic [7:0]  o_out_prio;
    logic        o_can_run;
    logic [7:0]  o_qry_prio;
    logic [4:0]  o_ready_count;
    logic [4:0]  o_pending_count;
    logic        o_last;

    sched_scoreboard sb = new();
    int          n_sent = 0;
    bit          hold_off = 0;
    bit [63:0]   last_added = 64'd1;

    dependency_priority_scheduler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_req_id(i_req_id), .i_pred_id(i_pred_id),
        .i_priority_req(i_priority_req), .i_batch_max(i_batch_max),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_out_id(o_out_id), .o_out_prio(o_out_prio),
        .o_can_run(o_can_run), .o_qry_prio(o_qry_prio),
        .o_ready_count(o_ready_count), .o_pending_count(o_pending_count),
        .o_last(o_last)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // receiver stall pattern, with one long hold-off on request
    always @(negedge i_clk) begin
        int mode;
        int cnt;
        if (cnt == 0) begin
            mode = $urandom_range(0, 3);
            cnt = $urandom_range(20, 80);
        end
        cnt--;
        case (mode)
            0: i_stall = hold_off;
            1: i_stall = hold_off | ($urandom_range(0, 9) < 3);
            2: i_stall = hold_off | (cnt % 4 == 0);
            default: i_stall = hold_off | ($urandom_range(0, 9) < 7);
        endcase
    end

    // result monitor
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.status = o_status;
            got.out_id = o_out_id;
            got.out_prio = o_out_prio;
            got.can_run = o_can_run;
            got.qry_prio = o_qry_prio;
            got.ready_count = o_ready_count;
            got.pending_count = o_pending_count;
            got.last = o_last;
            sb.check_result(got);
        end
    end

    // one long receiver hold-off while the sender keeps offering
    initial begin
        wait (n_sent >= 60);
        hold_off = 1;
        repeat (400) @(posedge i_clk);
        hold_off = 0;
    end

    // run limit
    initial begin
        #4ms;
        $display("FAIL");
        $finish;
    end

    // offer one operation and wait for its transfer; the sender may pause first
    task send_op(bit [2:0] kind, bit [63:0] id, bit [63:0] pred, bit [7:0] prio,
                 bit [4:0] bmax);
        int gap;
        @(negedge i_clk);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap != 0) begin
            i_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind = kind;
        i_req_id = id;
        i_pred_id = pred;
        i_priority_req = prio;
        i_batch_max = bmax;
        i_valid = 1;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(kind, id, pred, prio, bmax);
        n_sent++;
        if (kind == K_ADD) last_added = id;
    endtask

    task drain_and_set(bit [7:0] value);
        @(negedge i_clk);
        i_valid = 0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_data = value;
        @(posedge i_clk);
        sb.absent_prio = value;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    function bit [63:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 84) return 64'($urandom_range(1, 12));
        if (r < 89) return 64'd0;
        if (r < 94) return '1;
        return {$urandom(), $urandom()};
    endfunction

    function bit [7:0] pick_prio();
        int t;
        if ($urandom_range(0, 1) == 0) begin
            t = $urandom_range(0, 3);
            case (t)
                0: return 8'd0;
                1: return 8'd10;
                2: return 8'd128;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom());
    endfunction

    // random operation mix, biased toward dependency chains
    task random_ops(int count);
        int r;
        bit [2:0] kind;
        bit [63:0] pred;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 36) kind = K_ADD;
            else if (r < 51) kind = K_COMPLETE;
            else if (r < 68) kind = K_CANCEL;
            else if (r < 84) kind = K_DISPATCH;
            else if (r < 97) kind = K_QUERY;
            else kind = 3'($urandom_range(5, 7));
            r = $urandom_range(0, 9);
            pred = (r < 3) ? 64'd0 : (r < 7) ? last_added : pick_id();
            send_op(kind, pick_id(), pred, pick_prio(), 5'($urandom_range(0, 31)));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        drain_and_set(8'd0);

        // directed: unknown ids, empty dispatch, chains, boosts, unused kind
        send_op(K_QUERY, 64'd99, 0, 0, 1);
        send_op(K_COMPLETE, 64'd99, 0, 0, 1);
        send_op(K_CANCEL, 64'd99, 0, 0, 1);
        send_op(K_DISPATCH, 0, 0, 0, 5'd1);
        send_op(K_ADD, '1, 0, 8'd255, 1);
        send_op(K_ADD, 64'd0, 0, 8'd0, 1);
        send_op(K_ADD, 64'd5, '1, 8'd10, 1);
        send_op(K_ADD, 64'd6, 64'd5, 8'd200, 1);
        send_op(K_ADD, 64'd7, 0, 8'd100, 1);
        send_op(K_ADD, 64'd8, 64'd7, 8'd150, 1);
        send_op(K_ADD, 64'd9, 64'd9, 8'd150, 1);
        send_op(K_QUERY, 64'd7, 0, 0, 1);
        send_op(K_DISPATCH, 0, 0, 0, 5'd0);
        send_op(K_COMPLETE, '1, 0, 0, 1);
        send_op(K_QUERY, 64'd5, 0, 0, 1);
        send_op(K_CANCEL, 64'd5, 0, 0, 1);
        send_op(3'd7, 64'd1, 64'd1, 8'd1, 5'd31);
        send_op(K_DISPATCH, 0, 0, 0, 5'd31);
        // fill the table past its end
        for (int i = 0; i < 17; i++)
            send_op(K_ADD, 64'(100 + i), 64'(i == 0 ? 0 : 99 + i), 8'(i * 15), 1);
        send_op(K_DISPATCH, 0, 0, 0, 5'd16);
        send_op(K_CANCEL, 64'd100, 0, 0, 1);

        drain_and_set(8'd255);
        random_ops(45);
        drain_and_set(8'($urandom()));
        random_ops(45);
        drain_and_set(8'd4);
        random_ops(43);

        @(negedge i_clk);
        i_valid = 0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.n_fail == 0 && sb.expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
src/dps_pkg.sv
src/dps_front.sv
src/dps_engine.sv
src/dependency_priority_scheduler.sv
tb/tb.sv
